>>> rtl/tle_pkg.sv
package tle_pkg;

    typedef enum logic [2:0] {
        KIND_ECHO   = 3'd0,
        KIND_LINE   = 3'd1,
        KIND_EMPTY  = 3'd2,
        KIND_CANCEL = 3'd3,
        KIND_UP     = 3'd4,
        KIND_DOWN   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_BRACKET = 3'd2,
        MODE_DELKEY  = 3'd3,
        MODE_DROP    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT,
        ST_LREAD,
        ST_LPUSH
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SINGLE,
        ACT_RUBOUT,
        ACT_KILL,
        ACT_LINE
    } act_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  data;
        logic        last;
    } res_t;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_ETX      = 8'h03;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_XOFF     = 8'h13;
    localparam logic [7:0] CH_NAK      = 8'h15;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_ONE      = 8'h31;
    localparam logic [7:0] CH_TWO      = 8'h32;
    localparam logic [7:0] CH_THREE    = 8'h33;
    localparam logic [7:0] CH_FOUR     = 8'h34;
    localparam logic [7:0] CH_FIVE     = 8'h35;
    localparam logic [7:0] CH_SIX      = 8'h36;
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_B        = 8'h42;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_K        = 8'h4B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_DEL      = 8'h7F;

endpackage

>>> rtl/tle_line_ram.sv
module tle_line_ram #(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tle_ctrl.sv
module tle_ctrl #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    input  logic                             slot_free,
    output tle_pkg::res_t                    push,
    output logic                             ram_we,
    output logic [$clog2(LINE_CAPACITY)-1:0] ram_waddr,
    output logic [7:0]                       ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(LINE_CAPACITY)-1:0] ram_raddr,
    input  logic [7:0]                       ram_rdata
);

    localparam int CW = $clog2(LINE_CAPACITY + 1);
    localparam int AW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] CAP_C    = CW'(LINE_CAPACITY);
    localparam logic [CW-1:0] LEN_FULL = CW'(LINE_CAPACITY - 1);

    tle_pkg::state_t state_reg, state_next;
    tle_pkg::mode_t  mode_reg;
    logic            skip_reg;
    logic [CW-1:0]   count_reg;

    logic [7:0]      byte_reg;
    tle_pkg::act_t   act_reg;
    tle_pkg::kind_t  kind_reg;
    logic [7:0]      data_reg;
    logic [CW-1:0]   len_reg;
    logic [AW-1:0]   idx_reg;
    logic [3:0]      step_reg;
    logic [7:0]      dig_reg [3];
    logic [1:0]      ndig_reg;

    // decode of the held byte
    tle_pkg::mode_t  dec_mode;
    logic            dec_skip;
    logic [CW-1:0]   dec_count;
    tle_pkg::act_t   dec_act;
    tle_pkg::kind_t  dec_kind;
    logic [7:0]      dec_data;
    logic [CW-1:0]   dec_len;
    logic            dec_we;

    // decimal digits of the count for the kill-line echo
    logic [7:0]      n8;
    logic            hund;
    logic [6:0]      rem;
    logic [14:0]     prod;
    logic [3:0]      tens;
    logic [6:0]      units;
    logic [1:0]      ndig;

    // current result of a short sequence
    tle_pkg::kind_t  emit_kind;
    logic [7:0]      emit_data;
    logic            emit_last;
    logic [3:0]      k_pos;
    logic [3:0]      j_pos;
    logic [1:0]      dsel;
    logic            line_last;

    always_comb begin
        n8    = 8'(count_reg);
        hund  = (n8 >= 8'd100);
        rem   = hund ? 7'(n8 - 8'd100) : n8[6:0];
        prod  = 15'(rem) * 15'd205;
        tens  = prod[14:11];
        units = 7'(rem - 7'(tens) * 7'd10);
        ndig  = hund ? 2'd3 : ((n8 >= 8'd10) ? 2'd2 : 2'd1);
    end

    always_comb begin
        dec_mode  = tle_pkg::MODE_NORMAL;
        dec_skip  = skip_reg;
        dec_count = count_reg;
        dec_act   = tle_pkg::ACT_NONE;
        dec_kind  = tle_pkg::KIND_ECHO;
        dec_data  = byte_reg;
        dec_len   = count_reg;
        dec_we    = 1'b0;
        case (mode_reg)
            tle_pkg::MODE_ESC: begin
                if (byte_reg == tle_pkg::CH_LBRACKET) begin
                    dec_mode = tle_pkg::MODE_BRACKET;
                end
            end
            tle_pkg::MODE_BRACKET: begin
                if (byte_reg == tle_pkg::CH_A) begin
                    dec_act  = tle_pkg::ACT_SINGLE;
                    dec_kind = tle_pkg::KIND_UP;
                    dec_data = 8'd0;
                end else if (byte_reg == tle_pkg::CH_B) begin
                    dec_act  = tle_pkg::ACT_SINGLE;
                    dec_kind = tle_pkg::KIND_DOWN;
                    dec_data = 8'd0;
                end else if (byte_reg == tle_pkg::CH_THREE) begin
                    dec_mode = tle_pkg::MODE_DELKEY;
                end else if (byte_reg inside {tle_pkg::CH_ONE, tle_pkg::CH_TWO,
                                              tle_pkg::CH_FOUR, tle_pkg::CH_FIVE,
                                              tle_pkg::CH_SIX}) begin
                    dec_mode = tle_pkg::MODE_DROP;
                end
            end
            tle_pkg::MODE_DELKEY: begin
                if (byte_reg == tle_pkg::CH_TILDE && count_reg != '0) begin
                    dec_act   = tle_pkg::ACT_RUBOUT;
                    dec_count = count_reg - CW'(1);
                end
            end
            tle_pkg::MODE_DROP: begin
                dec_mode = tle_pkg::MODE_NORMAL;
            end
            default: begin
                if (count_reg >= CAP_C) begin
                    // full buffer: drop the byte, send all but the last stored byte
                    dec_act   = tle_pkg::ACT_LINE;
                    dec_len   = LEN_FULL;
                    dec_count = '0;
                end else if (byte_reg == tle_pkg::CH_XOFF) begin
                    dec_act = tle_pkg::ACT_NONE;
                end else if (byte_reg == tle_pkg::CH_NAK) begin
                    if (count_reg != '0) begin
                        dec_act   = tle_pkg::ACT_KILL;
                        dec_count = '0;
                    end
                end else if (byte_reg == tle_pkg::CH_ESC) begin
                    dec_mode = tle_pkg::MODE_ESC;
                end else if (skip_reg && (byte_reg == tle_pkg::CH_LF ||
                                          byte_reg == tle_pkg::CH_NUL)) begin
                    dec_skip = 1'b0;
                end else if (byte_reg == tle_pkg::CH_ETX) begin
                    dec_act   = tle_pkg::ACT_SINGLE;
                    dec_kind  = tle_pkg::KIND_CANCEL;
                    dec_data  = 8'd0;
                    dec_count = '0;
                end else if (byte_reg == tle_pkg::CH_BS || byte_reg == tle_pkg::CH_DEL) begin
                    if (count_reg != '0) begin
                        dec_act   = tle_pkg::ACT_RUBOUT;
                        dec_count = count_reg - CW'(1);
                    end
                end else if (byte_reg == tle_pkg::CH_CR || byte_reg == tle_pkg::CH_LF) begin
                    if (byte_reg == tle_pkg::CH_CR) begin
                        dec_skip = 1'b1;
                    end
                    if (count_reg == '0) begin
                        dec_act  = tle_pkg::ACT_SINGLE;
                        dec_kind = tle_pkg::KIND_EMPTY;
                        dec_data = 8'd0;
                    end else begin
                        dec_act = tle_pkg::ACT_LINE;
                    end
                    dec_count = '0;
                end else begin
                    dec_act   = tle_pkg::ACT_SINGLE;
                    dec_we    = 1'b1;
                    dec_count = count_reg + CW'(1);
                end
            end
        endcase
    end

    always_comb begin
        k_pos     = step_reg - 4'd2;
        j_pos     = k_pos - {2'b00, ndig_reg};
        dsel      = 2'(k_pos + 4'd3 - {2'b00, ndig_reg});
        emit_kind = tle_pkg::KIND_ECHO;
        emit_data = tle_pkg::CH_BS;
        emit_last = 1'b0;
        case (act_reg)
            tle_pkg::ACT_RUBOUT: begin
                emit_data = (step_reg == 4'd1) ? tle_pkg::CH_SPACE : tle_pkg::CH_BS;
                emit_last = (step_reg == 4'd2);
            end
            tle_pkg::ACT_KILL: begin
                if (step_reg == 4'd0) begin
                    emit_data = tle_pkg::CH_ESC;
                end else if (step_reg == 4'd1) begin
                    emit_data = tle_pkg::CH_LBRACKET;
                end else if (k_pos < {2'b00, ndig_reg}) begin
                    emit_data = dig_reg[dsel];
                end else begin
                    case (j_pos)
                        4'd0:    emit_data = tle_pkg::CH_D;
                        4'd1:    emit_data = tle_pkg::CH_ESC;
                        4'd2:    emit_data = tle_pkg::CH_LBRACKET;
                        default: emit_data = tle_pkg::CH_K;
                    endcase
                    emit_last = (j_pos == 4'd3);
                end
            end
            default: begin
                emit_kind = kind_reg;
                emit_data = data_reg;
                emit_last = 1'b1;
            end
        endcase
    end

    assign line_last = (CW'(idx_reg) + CW'(1)) == len_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tle_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = tle_pkg::ST_DECODE;
                end
            end
            tle_pkg::ST_DECODE: begin
                case (dec_act)
                    tle_pkg::ACT_NONE: state_next = tle_pkg::ST_IDLE;
                    tle_pkg::ACT_LINE: state_next = tle_pkg::ST_LREAD;
                    default:           state_next = tle_pkg::ST_EMIT;
                endcase
            end
            tle_pkg::ST_EMIT: begin
                if (slot_free && emit_last) begin
                    state_next = tle_pkg::ST_IDLE;
                end
            end
            tle_pkg::ST_LREAD: begin
                state_next = tle_pkg::ST_LPUSH;
            end
            tle_pkg::ST_LPUSH: begin
                if (slot_free) begin
                    state_next = line_last ? tle_pkg::ST_IDLE : tle_pkg::ST_LREAD;
                end
            end
            default: state_next = tle_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        push       = '0;
        push.kind  = tle_pkg::KIND_ECHO;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = count_reg[AW-1:0];
        ram_wdata  = byte_reg;
        ram_raddr  = idx_reg;
        case (state_reg)
            tle_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            tle_pkg::ST_DECODE: begin
                ram_we = dec_we;
            end
            tle_pkg::ST_EMIT: begin
                push.valid = slot_free;
                push.kind  = emit_kind;
                push.data  = emit_data;
                push.last  = emit_last;
            end
            tle_pkg::ST_LREAD: begin
                ram_re = 1'b1;
            end
            tle_pkg::ST_LPUSH: begin
                push.valid = slot_free;
                push.kind  = tle_pkg::KIND_LINE;
                push.data  = ram_rdata;
                push.last  = line_last;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tle_pkg::ST_IDLE;
            mode_reg  <= tle_pkg::MODE_NORMAL;
            skip_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == tle_pkg::ST_DECODE) begin
                mode_reg  <= dec_mode;
                skip_reg  <= dec_skip;
                count_reg <= dec_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            tle_pkg::ST_IDLE: begin
                if (s_valid) begin
                    byte_reg <= s_rx_byte;
                end
            end
            tle_pkg::ST_DECODE: begin
                act_reg    <= dec_act;
                kind_reg   <= dec_kind;
                data_reg   <= dec_data;
                len_reg    <= dec_len;
                idx_reg    <= '0;
                step_reg   <= 4'd0;
                ndig_reg   <= ndig;
                dig_reg[0] <= tle_pkg::CH_ZERO + 8'(hund);
                dig_reg[1] <= tle_pkg::CH_ZERO + 8'(tens);
                dig_reg[2] <= tle_pkg::CH_ZERO + 8'(units);
            end
            tle_pkg::ST_EMIT: begin
                if (slot_free) begin
                    step_reg <= step_reg + 4'd1;
                end
            end
            tle_pkg::ST_LPUSH: begin
                if (slot_free) begin
                    idx_reg <= idx_reg + AW'(1);
                end
            end
            default: begin
                step_reg <= step_reg;
            end
        endcase
    end

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("line buffer read and write in the same cycle");

    a_push_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> slot_free)
        else $error("result pushed into an occupied output register");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("character count beyond line capacity");

    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == tle_pkg::ST_DECODE))
        else $error("accepted byte not decoded in the next cycle");

    a_read_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tle_pkg::ST_LPUSH) |-> (CW'(idx_reg) < len_reg))
        else $error("line readout past its length");

endmodule

>>> rtl/terminal_line_editor_top.sv
// Terminal line editor: turns received terminal bytes into echo output,
// completed command lines and editing events.
// Input channel s_*: one request carries one received byte (s_rx_byte).
// Result channel m_*: one request carries kind, data and last; last marks
// the final result caused by one input byte. A byte may cause no result.
// An accepted byte is decoded in the DECODE state; its echo or event
// results are then pushed from the EMIT state. Completing a line of n
// bytes runs the LREAD and LPUSH states once per byte, one line buffer
// read and one result push per byte through the single read port of the
// line memory. Every result passes the output register.
// Reset (aresetn low, synchronous): the line count, escape mode and LF
// skip flag clear and the output register empties. The line memory is not
// cleared; only entries below the count are ever read.
// Receiver stall: the output register holds the pending result and the
// sequencer waits; a new byte is taken as soon as the previous byte's
// last result sits in the output register.
module terminal_line_editor_top #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_data,
    output logic       m_last
);

    localparam int AW = $clog2(LINE_CAPACITY);

    tle_pkg::res_t  push;
    logic           slot_free;
    logic           ram_we;
    logic           ram_re;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;

    logic           m_valid_reg;
    tle_pkg::kind_t m_kind_reg;
    logic [7:0]     m_data_reg;
    logic           m_last_reg;

    // Decoder and sequencer: edits the line, drives the line memory and
    // offers one result at a time.
    tle_ctrl #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .slot_free (slot_free),
        .push      (push),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Line buffer with registered read data.
    tle_line_ram #(
        .DEPTH(LINE_CAPACITY)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register takes a new result when empty or being drained.
    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the payload until the next push.
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            m_kind_reg <= push.kind;
            m_data_reg <= push.data;
            m_last_reg <= push.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

endmodule

>>> dv/tb_terminal_line_editor_top.sv
`timescale 1ns / 1ps

module tb_terminal_line_editor_top;

    localparam int unsigned LINE_CAPACITY = 64;
    // Abort well past the slowest legal run: every byte of a full line
    // waits out long receiver stalls and the sender gaps on top.
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASE_BYTES   = 6;

    // Idle and stall odds per phase, in percent of cycles.
    localparam int TX_IDLE_PCT [4] = '{0, 79, 0, 11};
    localparam int RX_STALL_PCT[4] = '{0, 0, 79, 11};

    localparam logic [7:0] DIGIT_KEYS[5] = '{tle_pkg::CH_ONE, tle_pkg::CH_TWO,
                                             tle_pkg::CH_FOUR, tle_pkg::CH_FIVE,
                                             tle_pkg::CH_SIX};
    localparam logic [7:0] EDIT_KEYS [8] = '{tle_pkg::CH_BS, tle_pkg::CH_DEL,
                                             tle_pkg::CH_NAK, tle_pkg::CH_ETX,
                                             tle_pkg::CH_XOFF, tle_pkg::CH_NUL,
                                             tle_pkg::CH_LF, tle_pkg::CH_CR};

    // One result of the editor as it leaves the m_ channel.
    typedef struct packed {
        tle_pkg::kind_t kind;
        logic [7:0]     data;
        logic           last;
    } term_res_t;

    // One row of the directed table. Where typed is set, the single result
    // (or the absence of one) is written out in the row; otherwise the
    // editor model below supplies it.
    typedef struct packed {
        logic [7:0]     rx;
        logic           typed;
        logic           has_res;
        tle_pkg::kind_t kind;
        logic [7:0]     data;
    } stim_row_t;

    localparam int DIRECTED_LEN = 27;
    localparam stim_row_t DIRECTED_ROWS[DIRECTED_LEN] = '{
        '{tle_pkg::CH_A, 1'b1, 1'b1, tle_pkg::KIND_ECHO, tle_pkg::CH_A},  // first byte
        '{8'hFF, 1'b1, 1'b1, tle_pkg::KIND_ECHO, 8'hFF},  // top of the byte range
        '{tle_pkg::CH_NUL, 1'b1, 1'b1, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL}, // no CR before
        '{tle_pkg::CH_DEL, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},  // rub out one character
        '{tle_pkg::CH_ESC, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},  // delete key: ESC [ 3 ~
        '{tle_pkg::CH_LBRACKET, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},
        '{tle_pkg::CH_THREE, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},
        '{tle_pkg::CH_TILDE, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},
        '{tle_pkg::CH_NAK, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},  // kill the rest of the line
        '{tle_pkg::CH_BS, 1'b1, 1'b0, tle_pkg::KIND_ECHO, 8'h00},   // backspace, empty line
        '{tle_pkg::CH_NAK, 1'b1, 1'b0, tle_pkg::KIND_ECHO, 8'h00},  // kill on an empty line
        '{tle_pkg::CH_XOFF, 1'b1, 1'b0, tle_pkg::KIND_ECHO, 8'h00}, // flow control swallowed
        '{tle_pkg::CH_CR, 1'b1, 1'b1, tle_pkg::KIND_EMPTY, 8'h00},  // empty line, arms LF skip
        '{tle_pkg::CH_LF, 1'b1, 1'b0, tle_pkg::KIND_ECHO, 8'h00},   // LF after CR swallowed
        '{tle_pkg::CH_CR, 1'b1, 1'b1, tle_pkg::KIND_EMPTY, 8'h00},
        '{tle_pkg::CH_NUL, 1'b1, 1'b0, tle_pkg::KIND_ECHO, 8'h00},  // NUL after CR swallowed
        '{tle_pkg::CH_ETX, 1'b1, 1'b1, tle_pkg::KIND_CANCEL, 8'h00}, // Ctrl-C
        '{tle_pkg::CH_ESC, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},  // arrow up
        '{tle_pkg::CH_LBRACKET, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},
        '{tle_pkg::CH_A, 1'b1, 1'b1, tle_pkg::KIND_UP, 8'h00},
        '{tle_pkg::CH_ESC, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},  // arrow down
        '{tle_pkg::CH_LBRACKET, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},
        '{tle_pkg::CH_B, 1'b1, 1'b1, tle_pkg::KIND_DOWN, 8'h00},
        '{tle_pkg::CH_ESC, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},  // page key: ESC [ 5 ~
        '{tle_pkg::CH_LBRACKET, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},
        '{tle_pkg::CH_FIVE, 1'b0, 1'b0, tle_pkg::KIND_ECHO, 8'h00},
        '{tle_pkg::CH_TILDE, 1'b1, 1'b0, tle_pkg::KIND_ECHO, 8'h00}
    };

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [2:0] m_kind;
    logic [7:0] m_data;
    logic       m_last;

    // Editor state as the bench sees it.
    logic [7:0]     line_mem[LINE_CAPACITY];
    int unsigned    line_len   = 0;
    tle_pkg::mode_t esc_state  = tle_pkg::MODE_NORMAL;
    bit             swallow_lf = 1'b0;

    term_res_t   step_q[$];          // results of the byte just taken
    term_res_t   pending_results[$]; // results still owed by the block

    int          tx_idle_pct    = 0;
    int          rx_stall_pct   = 0;
    int unsigned cycle_count    = 0;
    int unsigned bytes_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned lines_done     = 0;
    int unsigned events_seen    = 0;
    int unsigned mismatch_count = 0;

    terminal_line_editor_top #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_data    (m_data),
        .m_last    (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Editor model
    // ------------------------------------------------------------------

    function automatic void note_result(input tle_pkg::kind_t k, input logic [7:0] d);
        step_q.push_back(term_res_t'{kind: k, data: d, last: 1'b0});
    endfunction

    // Echo BS, space, BS and drop one character.
    function automatic void erase_char();
        note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_BS);
        note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_SPACE);
        note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_BS);
        line_len--;
    endfunction

    // Read the stored line out, or flag an empty line.
    function automatic void flush_line();
        if (line_len == 0) begin
            note_result(tle_pkg::KIND_EMPTY, 8'h00);
        end else begin
            for (int i = 0; i < line_len && i < LINE_CAPACITY; i++) begin
                note_result(tle_pkg::KIND_LINE, line_mem[i]);
            end
        end
        line_len = 0;
    endfunction

    // Advance the model by one received byte; leave its results in step_q.
    function automatic void predict_rx_byte(input logic [7:0] c);
        int unsigned n;
        step_q.delete();
        case (esc_state)
            tle_pkg::MODE_ESC: begin
                esc_state = (c == tle_pkg::CH_LBRACKET) ? tle_pkg::MODE_BRACKET
                                                        : tle_pkg::MODE_NORMAL;
            end
            tle_pkg::MODE_BRACKET: begin
                esc_state = tle_pkg::MODE_NORMAL;
                if (c == tle_pkg::CH_A) begin
                    note_result(tle_pkg::KIND_UP, 8'h00);
                end else if (c == tle_pkg::CH_B) begin
                    note_result(tle_pkg::KIND_DOWN, 8'h00);
                end else if (c == tle_pkg::CH_THREE) begin
                    esc_state = tle_pkg::MODE_DELKEY;
                end else if (c inside {tle_pkg::CH_ONE, tle_pkg::CH_TWO, tle_pkg::CH_FOUR,
                                       tle_pkg::CH_FIVE, tle_pkg::CH_SIX}) begin
                    esc_state = tle_pkg::MODE_DROP;
                end
            end
            tle_pkg::MODE_DELKEY: begin
                if (c == tle_pkg::CH_TILDE && line_len != 0) begin
                    erase_char();
                end
                esc_state = tle_pkg::MODE_NORMAL;
            end
            tle_pkg::MODE_DROP: begin
                esc_state = tle_pkg::MODE_NORMAL;
            end
            default: begin
                esc_state = tle_pkg::MODE_NORMAL;
                if (line_len >= LINE_CAPACITY) begin
                    // Full buffer: drop the byte, send all but the last slot.
                    line_len = LINE_CAPACITY - 1;
                    flush_line();
                end else if (c == tle_pkg::CH_XOFF) begin
                    // swallowed
                end else if (c == tle_pkg::CH_NAK) begin
                    if (line_len != 0) begin
                        n = line_len;
                        note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_ESC);
                        note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_LBRACKET);
                        if (n >= 100) begin
                            note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_ZERO + 8'(n / 100));
                        end
                        if (n >= 10) begin
                            note_result(tle_pkg::KIND_ECHO,
                                        tle_pkg::CH_ZERO + 8'((n / 10) % 10));
                        end
                        note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_ZERO + 8'(n % 10));
                        note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_D);
                        note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_ESC);
                        note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_LBRACKET);
                        note_result(tle_pkg::KIND_ECHO, tle_pkg::CH_K);
                        line_len = 0;
                    end
                end else if (c == tle_pkg::CH_ESC) begin
                    esc_state = tle_pkg::MODE_ESC;
                end else if (swallow_lf && (c == tle_pkg::CH_LF || c == tle_pkg::CH_NUL)) begin
                    swallow_lf = 1'b0;
                end else if (c == tle_pkg::CH_ETX) begin
                    note_result(tle_pkg::KIND_CANCEL, 8'h00);
                    line_len = 0;
                end else if (c == tle_pkg::CH_BS || c == tle_pkg::CH_DEL) begin
                    if (line_len != 0) begin
                        erase_char();
                    end
                end else if (c == tle_pkg::CH_CR) begin
                    swallow_lf = 1'b1;
                    flush_line();
                end else if (c == tle_pkg::CH_LF) begin
                    flush_line();
                end else begin
                    note_result(tle_pkg::KIND_ECHO, c);
                    line_mem[line_len] = c;
                    line_len++;
                end
            end
        endcase
        if (step_q.size() != 0) begin
            step_q[step_q.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte, hold it until the request completes, then record
    // what it owes. A typed row replaces the model's results with its own.
    task automatic send_rx(input logic [7:0] b, input bit typed = 1'b0,
                           input bit has_res = 1'b0,
                           input tle_pkg::kind_t k = tle_pkg::KIND_ECHO,
                           input logic [7:0] d = 8'h00);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_rx_byte(b);
        if (typed) begin
            step_q.delete();
            if (has_res) begin
                step_q.push_back(term_res_t'{kind: k, data: d, last: 1'b1});
            end
        end
        foreach (step_q[i]) begin
            pending_results.push_back(step_q[i]);
        end
        bytes_sent++;
    endtask

    // Hold the input idle until every owed result has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // A byte the editor stores as text: mostly printable, else any byte
    // with no editing meaning (other control codes, high half).
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        if ($urandom_range(9) < 7) begin
            b = 8'($urandom_range(8'h7E, 8'h20));
        end else begin
            do begin
                b = 8'($urandom_range(255));
            end while (b inside {tle_pkg::CH_NUL, tle_pkg::CH_ETX, tle_pkg::CH_BS,
                                 tle_pkg::CH_LF, tle_pkg::CH_CR, tle_pkg::CH_XOFF,
                                 tle_pkg::CH_NAK, tle_pkg::CH_ESC, tle_pkg::CH_DEL});
        end
        return b;
    endfunction

    // Typed command line with the odd correction, closed by CR, LF,
    // kill or cancel. Lines are short except now and then.
    task automatic send_word();
        int unsigned len;
        int unsigned pick;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(12);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 12) begin
                if ($urandom_range(1) == 0) begin
                    send_rx($urandom_range(1) ? tle_pkg::CH_BS : tle_pkg::CH_DEL);
                end else begin
                    send_rx(tle_pkg::CH_ESC);
                    send_rx(tle_pkg::CH_LBRACKET);
                    send_rx(tle_pkg::CH_THREE);
                    send_rx(tle_pkg::CH_TILDE);
                end
            end else begin
                send_rx(text_byte());
            end
        end
        pick = $urandom_range(99);
        if (pick < 45) begin
            send_rx(tle_pkg::CH_CR);
            pick = $urandom_range(9);
            if (pick < 5) begin
                send_rx(tle_pkg::CH_LF);
            end else if (pick == 5) begin
                send_rx(tle_pkg::CH_NUL);
            end
        end else if (pick < 75) begin
            send_rx(tle_pkg::CH_LF);
        end else if (pick < 88) begin
            send_rx(tle_pkg::CH_NAK);
        end else begin
            send_rx(tle_pkg::CH_ETX);
        end
    endtask

    // Escape sequences, good and bad.
    task automatic send_escape();
        send_rx(tle_pkg::CH_ESC);
        case ($urandom_range(6))
            0: begin
                send_rx(tle_pkg::CH_LBRACKET);
                send_rx(tle_pkg::CH_A);
            end
            1: begin
                send_rx(tle_pkg::CH_LBRACKET);
                send_rx(tle_pkg::CH_B);
            end
            2: begin
                send_rx(tle_pkg::CH_LBRACKET);
                send_rx(tle_pkg::CH_THREE);
                send_rx(tle_pkg::CH_TILDE);
            end
            3: begin
                send_rx(tle_pkg::CH_LBRACKET);
                send_rx(tle_pkg::CH_THREE);
                send_rx(8'($urandom_range(255)));
            end
            4: begin
                send_rx(tle_pkg::CH_LBRACKET);
                send_rx(DIGIT_KEYS[$urandom_range(4)]);
                send_rx(8'($urandom_range(255)));
            end
            5: begin
                send_rx(tle_pkg::CH_LBRACKET);
                send_rx(8'($urandom_range(255)));
            end
            default: begin
                send_rx(8'($urandom_range(255)));
            end
        endcase
    endtask

    // Fill the buffer to the brim, then one more byte: it is dropped and
    // the line goes out one short of capacity.
    task automatic fill_line();
        int unsigned room;
        if (esc_state != tle_pkg::MODE_NORMAL) begin
            send_rx(8'h71);  // lower-case letter ends any escape sequence
        end
        room = LINE_CAPACITY - line_len;
        repeat (room) begin
            send_rx(text_byte());
        end
        send_rx(8'($urandom_range(255)));
    endtask

    task automatic send_burst();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            send_word();
        end else if (pick < 65) begin
            send_escape();
        end else if (pick < 80) begin
            repeat ($urandom_range(3, 1)) begin
                send_rx(EDIT_KEYS[$urandom_range(7)]);
            end
        end else begin
            repeat ($urandom_range(4, 1)) begin
                send_rx(8'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: sample at the edge, then roll the stall for next cycle.
    // ------------------------------------------------------------------

    task automatic check_result();
        term_res_t want;
        results_seen++;
        if (m_kind == tle_pkg::KIND_EMPTY || (m_kind == tle_pkg::KIND_LINE && m_last)) begin
            lines_done++;
        end
        if (m_kind inside {tle_pkg::KIND_CANCEL, tle_pkg::KIND_UP, tle_pkg::KIND_DOWN}) begin
            events_seen++;
        end
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d data %02h last %0d",
                                      m_kind, m_data, m_last));
        end else begin
            want = pending_results.pop_front();
            if (m_kind !== want.kind) begin
                report_mismatch($sformatf("kind %0d, want %0d", m_kind, want.kind));
            end
            if (m_data !== want.data) begin
                report_mismatch($sformatf("data %02h, want %02h", m_data, want.data));
            end
            if (m_last !== want.last) begin
                report_mismatch($sformatf("last %0d, want %0d", m_last, want.last));
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result();
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: give up once the run has gone far past any sane length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still owed",
                 cycle_count, pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        // Hold reset low from the start, then release it once.
        repeat (10) begin
            @(posedge aclk);
        end
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table with light idling on both sides.
        tx_idle_pct  = 11;
        rx_stall_pct = 11;
        foreach (DIRECTED_ROWS[i]) begin
            send_rx(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].has_res,
                    DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].data);
        end
        drain_results();

        // Random traffic, one idling profile per phase. Drain between
        // phases so the sender sits out until the block has caught up.
        for (int p = 0; p < 4; p++) begin
            int unsigned phase_start;
            tx_idle_pct  = TX_IDLE_PCT[p];
            rx_stall_pct = RX_STALL_PCT[p];
            phase_start  = bytes_sent;
            if (p == 3) begin
                fill_line();
            end
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                send_burst();
            end
            drain_results();
        end

        // Let any stray result surface before judging.
        rx_stall_pct = 0;
        repeat (40) begin
            @(posedge aclk);
        end
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("Sent %0d bytes and checked %0d results: %0d lines, %0d events",
                 bytes_sent, results_seen, lines_done, events_seen);
        $display("Covered editing keys, escape decoding, LF skip, full buffer, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/tle_pkg.sv
rtl/tle_line_ram.sv
rtl/tle_ctrl.sv
rtl/terminal_line_editor_top.sv
dv/tb_terminal_line_editor_top.sv
